// ===== hdl/bias_field_neighbor_update_defines.svh =====
// ---------------------------------------------------------------------------
// Bias-field neighbor update: assertion macros
// Shared property shorthands, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef BIAS_FIELD_NEIGHBOR_UPDATE_DEFINES_SVH
`define BIAS_FIELD_NEIGHBOR_UPDATE_DEFINES_SVH

// same-cycle implication
`define BFNU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFNU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bfnu_pkg.sv =====
// ---------------------------------------------------------------------------
// Bias-field neighbor update package
// Widths, register indexes and shared types.
// ---------------------------------------------------------------------------
package bfnu_pkg;

  localparam int VOX_W  = 16;   // voxel index
  localparam int VAL_W  = 24;   // Q12.12 bias / intensity / mean
  localparam int WGT_W  = 16;   // Q4.12 weight
  localparam int WSUM_W = 20;   // Q8.12 weight total
  localparam int ACC_W  = 48;   // Q24.24 accumulator
  localparam int SD2_W  = 32;
  localparam int GS_W   = 40;
  localparam int DEN_W  = 61;
  localparam int NUM_W  = 88;   // numerator magnitude
  localparam int MUL_W  = 24;   // shared multiplier operand width
  localparam int CLS_N  = 3;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;
  localparam int VOXELS = 1 << VOX_W;

  localparam logic [IDX_W-1:0] REG_GAMMA  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MEAN_0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_MEAN_1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_MEAN_2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_SD_0   = 3'd4;
  localparam logic [IDX_W-1:0] REG_SD_1   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SD_2   = 3'd6;

  localparam logic [CFG_W-1:0] GAMMA_RST = 24'd65536;
  localparam logic [CFG_W-1:0] SD_RST    = 24'd65536;
  localparam logic [DEN_W-1:0] ONE_Q28   = DEN_W'(1) << 28;
  localparam logic [VAL_W-1:0] SAT_HI    = 24'h7FFFFF;
  localparam logic [VAL_W-1:0] SAT_LO    = 24'h800000;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // highest set class flag, class 0 when none is set
  function automatic logic [1:0] class_of(input logic [CLS_N-1:0] flags);
    logic [1:0] c;
    c = 2'd0;
    if (flags[1]) c = 2'd1;
    if (flags[2]) c = 2'd2;
    return c;
  endfunction

endpackage

// ===== hdl/bias_field_neighbor_update.sv =====
// ---------------------------------------------------------------------------
// Bias-field neighbor update
// Per-voxel bias store with neighbor accumulation and in-place update.
// ---------------------------------------------------------------------------
// One item at a time; s_axis_tready is high only while the sequencer is
// idle. A load item (tuser 0) is written to the store as it is accepted. A
// neighbor item runs store read, multiply and accumulate through the shared
// 24x24 multiplier. A neighbor item with tlast set then runs the update:
// nine multiply/add steps on the same multiplier (sd^2, gamma*sd^2, the
// denominator, then |acc|*gs in four partial products), then forms the
// numerator and runs the restoring divider, which dominates the time. The
// result goes out through an output register, so the block takes the next
// item while it waits on m_axis_tready. The 64K x 24 store has no reset;
// reading a voxel never loaded returns whatever the RAM holds. Config writes
// are taken any time but belong only in idle periods.
// ---------------------------------------------------------------------------
`include "bias_field_neighbor_update_defines.svh"

module bias_field_neighbor_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // voxel_index, load_value, neighbor_index, neighbor_weight, intensity,
  // class_flags, neighbor_weight_sum, one pad bit
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // action
  input  logic         s_axis_tlast,   // last_neighbor
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // updated_voxel, new_bias
  output logic         m_axis_tuser,   // saturated
  input  logic         cfg_we,
  input  logic [bfnu_pkg::IDX_W-1:0] cfg_index,
  input  logic [bfnu_pkg::CFG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NB_MUL, ST_NB_ADD, ST_UP_MUL, ST_UP_ADD,
    ST_UP_NUM, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'd8;

  state_t state;

  // input fields
  logic [15:0] in_vox, in_nidx, in_wgt;
  logic [23:0] in_load, in_inten;
  logic [2:0]  in_flags;
  logic [19:0] in_wsum;
  logic        accept;

  assign in_vox   = s_axis_tdata[15:0];
  assign in_load  = s_axis_tdata[39:16];
  assign in_nidx  = s_axis_tdata[55:40];
  assign in_wgt   = s_axis_tdata[71:56];
  assign in_inten = s_axis_tdata[95:72];
  assign in_flags = s_axis_tdata[98:96];
  assign in_wsum  = s_axis_tdata[118:99];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // config registers
  logic [23:0] gamma;
  logic [23:0] mean [bfnu_pkg::CLS_N];
  logic [23:0] sd   [bfnu_pkg::CLS_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma   <= bfnu_pkg::GAMMA_RST;
      mean[0] <= '0;
      mean[1] <= '0;
      mean[2] <= '0;
      sd[0]   <= bfnu_pkg::SD_RST;
      sd[1]   <= bfnu_pkg::SD_RST;
      sd[2]   <= bfnu_pkg::SD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfnu_pkg::REG_GAMMA:  gamma   <= cfg_data;
        bfnu_pkg::REG_MEAN_0: mean[0] <= cfg_data;
        bfnu_pkg::REG_MEAN_1: mean[1] <= cfg_data;
        bfnu_pkg::REG_MEAN_2: mean[2] <= cfg_data;
        bfnu_pkg::REG_SD_0:   sd[0]   <= cfg_data;
        bfnu_pkg::REG_SD_1:   sd[1]   <= cfg_data;
        bfnu_pkg::REG_SD_2:   sd[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers
  logic [15:0] vox, wgt;
  logic        last;
  logic [23:0] inten;
  logic [1:0]  cls;
  logic [19:0] wsum;

  // bias store
  logic [23:0] store [bfnu_pkg::VOXELS];
  logic [23:0] rdata;
  logic        mem_we;
  logic [15:0] mem_addr;
  logic [23:0] mem_wdata;

  // datapath
  logic [47:0] acc, p;
  logic [31:0] sd2;
  logic [39:0] gs;
  logic [60:0] den;
  logic [87:0] mac, addend, mac_sum;
  logic [3:0]  step;
  logic [24:0] dlt;
  logic [87:0] num_mag;
  logic        neg;
  logic [23:0] mul_a, mul_b, rd_mag;
  logic [47:0] mul_p, acc_mag;
  logic [88:0] num_s, num_abs;
  logic        out_free;
  logic [23:0] mean_sel, sd_sel;

  // divider
  bfnu_pkg::div_stat_t div_stat;
  logic [87:0] quot;
  logic        q_sat;
  logic [23:0] q_val;

  assign mean_sel = mean[cls];
  assign sd_sel   = sd[cls];
  assign rd_mag   = rdata[23] ? 24'(-rdata) : rdata;
  assign acc_mag  = acc[47] ? 48'(-acc) : acc;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // shared multiplier operand select
  always_comb begin
    mul_a = rd_mag;
    mul_b = {8'b0, wgt};
    if (state == ST_UP_MUL) begin
      case (step)
        4'd0: begin mul_a = sd_sel;              mul_b = sd_sel;              end
        4'd1: begin mul_a = gamma;               mul_b = sd2[23:0];           end
        4'd2: begin mul_a = gamma;               mul_b = {16'b0, sd2[31:24]}; end
        4'd3: begin mul_a = {4'b0, wsum};        mul_b = gs[23:0];            end
        4'd4: begin mul_a = {4'b0, wsum};        mul_b = {8'b0, gs[39:24]};   end
        4'd5: begin mul_a = acc_mag[23:0];       mul_b = gs[23:0];            end
        4'd6: begin mul_a = acc_mag[23:0];       mul_b = {8'b0, gs[39:24]};   end
        4'd7: begin mul_a = acc_mag[47:24];      mul_b = gs[23:0];            end
        default: begin mul_a = acc_mag[47:24];   mul_b = {8'b0, gs[39:24]};   end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // partial product alignment and accumulate
  always_comb begin
    case (step) inside
      4'd2, 4'd4, 4'd6, 4'd7: addend = {40'b0, p} << 24;
      4'd8:                   addend = {40'b0, p} << 48;
      default:                addend = {40'b0, p};
    endcase
    if (step == 4'd1 || step == 4'd3 || step == 4'd5) begin
      mac_sum = addend;
    end else begin
      mac_sum = mac + addend;
    end
  end

  // numerator: +-|acc|*gs + (intensity - mean) << 28
  assign num_s   = (acc[47] ? 89'(-{1'b0, mac}) : {1'b0, mac})
                 + {{36{dlt[24]}}, dlt, 28'b0};
  assign num_abs = num_s[88] ? 89'(-num_s) : num_s;

  // quotient clamp to Q12.12
  always_comb begin
    if (neg) begin
      q_sat = (|quot[87:24]) || (quot[23:0] > bfnu_pkg::SAT_LO);
      q_val = q_sat ? bfnu_pkg::SAT_LO : 24'(-quot[23:0]);
    end else begin
      q_sat = |quot[87:23];
      q_val = q_sat ? bfnu_pkg::SAT_HI : quot[23:0];
    end
  end

  bfnu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_DIV_GO),
    .num   (num_mag),
    .den   (den),
    .stat  (div_stat),
    .quot  (quot)
  );

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = in_vox;
    mem_wdata = in_load;
    if (accept && !s_axis_tuser) begin
      mem_we = 1'b1;
    end else if (state == ST_OUT && out_free) begin
      mem_we    = 1'b1;
      mem_addr  = vox;
      mem_wdata = q_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    if (accept) begin
      rdata <= store[in_nidx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      acc           <= '0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // ST_OUT sets tvalid itself when it retires
      if (m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            vox   <= in_vox;
            wgt   <= in_wgt;
            last  <= s_axis_tlast;
            inten <= in_inten;
            cls   <= bfnu_pkg::class_of(in_flags);
            wsum  <= in_wsum;
            if (s_axis_tuser) begin
              state <= ST_NB_MUL;
            end
          end
        end
        ST_NB_MUL: begin
          p     <= mul_p;
          state <= ST_NB_ADD;
        end
        ST_NB_ADD: begin
          acc  <= acc + (rdata[23] ? 48'(-p) : p);
          dlt  <= {inten[23], inten} - {mean_sel[23], mean_sel};
          step <= '0;
          state <= last ? ST_UP_MUL : ST_IDLE;
        end
        ST_UP_MUL: begin
          p     <= mul_p;
          state <= ST_UP_ADD;
        end
        ST_UP_ADD: begin
          case (step)
            4'd0:    sd2 <= p[47:16];
            4'd2:    gs  <= mac_sum[55:16];
            4'd4:    den <= mac_sum[60:0] + bfnu_pkg::ONE_Q28;
            default: mac <= mac_sum;
          endcase
          if (step == LAST_STEP) begin
            state <= ST_UP_NUM;
          end else begin
            step  <= step + 4'd1;
            state <= ST_UP_MUL;
          end
        end
        ST_UP_NUM: begin
          neg     <= num_s[88];
          num_mag <= num_abs[87:0];
          state   <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {q_val, vox};
            m_axis_tuser  <= q_sat;
            acc           <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BFNU_ASSERT_NEXT(a_load_keeps_acc, accept && !s_axis_tuser, $stable(acc), "load changed acc")
  `BFNU_ASSERT_IMPL(a_div_only_in_div, state != ST_DIV_GO && state != ST_DIV_WAIT, !div_stat.busy, "divider busy outside division")
  `BFNU_ASSERT_NEXT(a_out_clears_acc, state == ST_OUT && out_free, acc == '0 && m_axis_tvalid, "update did not retire")
  `BFNU_ASSERT_IMPL(a_step_range, state == ST_UP_MUL || state == ST_UP_ADD, step <= LAST_STEP, "step out of range")

endmodule

// ===== hdl/bfnu_div.sv =====
// ---------------------------------------------------------------------------
// Bias-field neighbor update: restoring divider
// Unsigned numerator by denominator, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bfnu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bfnu_pkg::NUM_W-1:0]  num,
  input  logic [bfnu_pkg::DEN_W-1:0]  den,
  output bfnu_pkg::div_stat_t         stat,
  output logic [bfnu_pkg::NUM_W-1:0]  quot
);

  logic [bfnu_pkg::DEN_W-1:0] rem;
  logic [bfnu_pkg::NUM_W-1:0] dvd;
  logic [6:0]                 cnt;
  logic [bfnu_pkg::DEN_W:0]   trial;
  logic                       ge;

  assign trial = {rem, dvd[bfnu_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem       <= '0;
        dvd       <= num;
        cnt       <= 7'(bfnu_pkg::NUM_W - 1);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem  <= ge ? bfnu_pkg::DEN_W'(trial - {1'b0, den}) : bfnu_pkg::DEN_W'(trial);
        quot <= {quot[bfnu_pkg::NUM_W-2:0], ge};
        dvd  <= dvd << 1;
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// Bias-field neighbor update testbench
// Streams load items and neighbor items into the block. An in-bench model
// predicts each voxel update, and every result item is compared against it
// field by field. Three phases of register settings run, each with its own
// idle pattern.
// ---------------------------------------------------------------------------
typedef struct {
  bit               action;
  logic [15:0]      voxel;
  logic [23:0]      load_value;
  logic [15:0]      nbr_index;
  logic [15:0]      nbr_weight;
  bit               last;
  logic [23:0]      intensity;
  logic [2:0]       flags;
  logic [19:0]      weight_sum;
} bias_item_t;

typedef struct {
  logic [15:0] voxel;
  logic [23:0] bias;
  bit          sat;
} bias_update_t;

class bias_update_predictor;
  logic [23:0]  regs [0:6];
  logic [23:0]  bias_mem [int];
  logic [47:0]  acc;
  bias_update_t expected_updates [$];
  int           errors;

  function new();
    regs[bfnu_pkg::REG_GAMMA] = bfnu_pkg::GAMMA_RST;
    regs[bfnu_pkg::REG_MEAN_0] = '0;
    regs[bfnu_pkg::REG_MEAN_1] = '0;
    regs[bfnu_pkg::REG_MEAN_2] = '0;
    regs[bfnu_pkg::REG_SD_0] = bfnu_pkg::SD_RST;
    regs[bfnu_pkg::REG_SD_1] = bfnu_pkg::SD_RST;
    regs[bfnu_pkg::REG_SD_2] = bfnu_pkg::SD_RST;
    acc = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] val);
    // index 7 has no register behind it
    if (idx <= bfnu_pkg::REG_SD_2) regs[idx] = val;
  endfunction

  function void note_item(bias_item_t it);
    int unsigned      cls;
    logic [23:0]      stored;
    longint           prod, diff;
    logic [63:0]      sd, sd2, gs, den;
    logic signed [127:0] num;
    logic [127:0]     mag, quo;
    bias_update_t     u;
    if (!it.action) begin
      bias_mem[int'(it.voxel)] = it.load_value;
      return;
    end
    stored = bias_mem.exists(int'(it.nbr_index)) ? bias_mem[int'(it.nbr_index)] : '0;
    prod = longint'($signed(stored)) * longint'(it.nbr_weight);
    acc = acc + prod[47:0];
    if (!it.last) return;
    // highest set flag wins, none set means class 0
    cls = 0;
    for (int j = 0; j < 3; j++)
      if (it.flags[j]) cls = j;
    sd   = 64'(regs[bfnu_pkg::REG_SD_0 + cls]);
    sd2  = (sd * sd) >> 16;
    gs   = (64'(regs[bfnu_pkg::REG_GAMMA]) * sd2) >> 16;
    den  = 64'(it.weight_sum) * gs + (64'd1 << 28);
    diff = longint'($signed(it.intensity))
         - longint'($signed(regs[bfnu_pkg::REG_MEAN_0 + cls]));
    num  = $signed({{80{acc[47]}}, acc}) * $signed({88'd0, gs[39:0]})
           + ($signed({{64{diff[63]}}, diff}) <<< 28);
    mag  = num[127] ? 128'(-num) : 128'(num);
    quo  = mag / {64'd0, den};
    u.voxel = it.voxel;
    u.sat = 0;
    if (num[127]) begin
      if (quo > 128'd8388608) begin
        quo = 128'd8388608;
        u.sat = 1;
      end
      u.bias = 24'(-quo);
    end else begin
      if (quo > 128'd8388607) begin
        quo = 128'd8388607;
        u.sat = 1;
      end
      u.bias = quo[23:0];
    end
    bias_mem[int'(it.voxel)] = u.bias;
    acc = '0;
    expected_updates.push_back(u);
  endfunction

  function void check_update(logic [15:0] voxel, logic [23:0] bias, bit sat);
    bias_update_t e;
    if (expected_updates.size() == 0) begin
      $error("unexpected result item: voxel %0d bias %h", voxel, bias);
      errors++;
      return;
    end
    e = expected_updates.pop_front();
    if (voxel !== e.voxel) begin
      $error("updated_voxel: expected %0d actual %0d", e.voxel, voxel);
      errors++;
    end
    if (bias !== e.bias) begin
      $error("new_bias: expected %h actual %h", e.bias, bias);
      errors++;
    end
    if (sat !== e.sat) begin
      $error("saturated: expected %0d actual %0d", e.sat, sat);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 200;   // covers one full update

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we = 0;
  logic [bfnu_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bfnu_pkg::CFG_W-1:0] cfg_data = '0;

  bias_update_predictor model = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 0;
  int          hold_cnt = 0;
  longint      cycles = 0;

  // voxels written so far; neighbor reads only ever target these
  bit          loaded [int];
  int          loaded_list [$];

  bias_field_neighbor_update DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bias_field_neighbor_update verification failed");
      $finish;
    end
  end

  // result side: check on handshake, then pick next tready
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        model.check_update(m_axis_tdata[15:0], m_axis_tdata[39:16], m_axis_tuser);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic mark_loaded(int idx);
    if (!loaded.exists(idx)) begin
      loaded[idx] = 1;
      loaded_list.push_back(idx);
    end
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  task automatic send(bias_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= it.action;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {1'b0, it.weight_sum, it.flags, it.intensity, it.nbr_weight,
                      it.nbr_index, it.load_value, it.voxel};
    do @(posedge clk); while (!s_axis_tready);
    model.note_item(it);
    if (!it.action) mark_loaded(int'(it.voxel));
    else if (it.last) mark_loaded(int'(it.voxel));
  endtask

  function automatic bias_item_t rand_item();
    bias_item_t it;
    it.action     = 1'($urandom_range(1));
    it.voxel      = 16'($urandom);
    it.load_value = 24'($urandom);
    it.nbr_index  = 16'($urandom);
    it.nbr_weight = 16'($urandom);
    it.last       = 1'($urandom_range(1));
    it.intensity  = 24'($urandom);
    it.flags      = 3'($urandom);
    it.weight_sum = 20'($urandom);
    return it;
  endfunction

  task automatic send_load(logic [15:0] vox, logic [23:0] val);
    bias_item_t it;
    it = rand_item();
    it.action = 0;
    it.voxel = vox;
    it.load_value = val;
    send(it);
  endtask

  task automatic send_term(logic [15:0] w, bit last, logic [15:0] vox,
                           logic [23:0] inten, logic [2:0] flags, logic [19:0] wsum);
    bias_item_t it;
    it = rand_item();
    it.action = 1;
    it.nbr_index = 16'(pick_loaded());
    it.nbr_weight = w;
    it.last = last;
    it.voxel = vox;
    it.intensity = inten;
    it.flags = flags;
    it.weight_sum = wsum;
    send(it);
  endtask

  // one well-formed voxel sweep step with random content
  task automatic send_sweep(output int n);
    int len;
    bias_item_t it;
    len = $urandom_range(1, 8);
    n = 0;
    for (int k = 0; k < len; k++) begin
      // stray load in the middle; it must not disturb the sum
      if ($urandom_range(9) == 0) begin
        send_load(16'($urandom), 24'($urandom));
        n++;
      end
      it = rand_item();
      it.action = 1;
      it.nbr_index = 16'(pick_loaded());
      if ($urandom_range(1)) it.nbr_weight = 16'($urandom_range(8192));
      it.last = (k == len - 1);
      if ($urandom_range(1)) it.weight_sum = 20'($urandom_range(32768));
      send(it);
      n++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (model.expected_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [23:0] vals [0:6]);
    for (int i = 0; i <= bfnu_pkg::REG_SD_2; i++) begin
      cfg_we <= 1;
      cfg_index <= bfnu_pkg::IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      model.write_reg(bfnu_pkg::IDX_W'(i), vals[i]);
    end
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count, bit hold_mid, bit pause_mid);
    int done, n;
    done = 0;
    while (done < count) begin
      if ($urandom_range(3) == 0) begin
        send_load(16'($urandom), 24'($urandom));
        done++;
      end else begin
        send_sweep(n);
        done += n;
      end
      if (hold_mid && done >= count / 2) begin
        hold_mid = 0;
        hold_req = 1;
      end
      if (pause_mid && done >= count / 2) begin
        pause_mid = 0;
        drain();
      end
    end
  endtask

  initial begin
    logic [23:0] vals [0:6];
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // phase 1: extremes of means and sd, sender idles more lightly
    vals = '{24'h010000, 24'h800000, 24'h7FFFFF, 24'h001000,
             24'h000001, 24'hFFFFFF, 24'h010000};
    write_regs(vals);
    send_idle_pct = 36;
    recv_idle_pct = 45;

    // directed: extreme loads and voxel indexes
    send_load(16'd0, 24'h7FFFFF);
    send_load(16'hFFFF, 24'h800000);
    send_load(16'd5, 24'h000000);
    send_load(16'd6, 24'h001000);
    // every class selection incl. no flag and several flags
    for (int f = 0; f < 8; f++)
      send_term(16'h1000, 1, 16'(f + 10), 24'(f * 24'h012345), 3'(f), 20'h01000);
    // zero and full weight, extreme intensities and weight sums
    send_term(16'h0000, 0, 16'd0, 24'h0, 3'b001, 20'd0);
    send_term(16'hFFFF, 1, 16'hFFFF, 24'h7FFFFF, 3'b010, 20'd0);
    send_term(16'hFFFF, 0, 16'd0, 24'h0, 3'b000, 20'd0);
    send_term(16'hFFFF, 1, 16'd1, 24'h800000, 3'b001, 20'hFFFFF);
    send_term(16'h0000, 1, 16'd2, 24'h800000, 3'b100, 20'd0);
    send_term(16'h0000, 1, 16'd3, 24'h7FFFFF, 3'b000, 20'hFFFFF);
    // a load with tlast set is still only a load
    begin
      bias_item_t it;
      it = rand_item();
      it.action = 0;
      it.last = 1;
      send(it);
    end
    random_phase(180, 1, 0);
    drain();
    repeat (SETTLE) @(posedge clk);

    // phase 2: max gamma, random means/sd, plus a write to the unused index
    vals = '{24'hFFFFFF, 24'($urandom), 24'($urandom), 24'($urandom),
             24'($urandom_range(1, 24'h20000)), 24'($urandom_range(1, 24'hFFFFFF)),
             24'($urandom_range(1, 24'h4000))};
    write_regs(vals);
    cfg_we <= 1;
    cfg_index <= 3'd7;
    cfg_data <= 24'hABCDEF;
    @(posedge clk);
    cfg_we <= 0;
    send_idle_pct = 45;
    recv_idle_pct = 36;
    random_phase(200, 0, 1);
    drain();
    repeat (SETTLE) @(posedge clk);

    // phase 3: zero gamma makes the update intensity - mean; no idling
    vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'($urandom),
             24'hFFFFFF, 24'h000001, 24'($urandom_range(1, 24'hFFFFFF))};
    write_regs(vals);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(100, 0, 0);
    drain();
    repeat (SETTLE) @(posedge clk);
    vals[0] = 24'h002000;
    write_regs(vals);
    random_phase(100, 1, 0);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (model.expected_updates.size() != 0) begin
      $error("%0d expected result items never arrived", model.expected_updates.size());
      model.errors++;
    end
    if (model.errors == 0)
      $display("bias_field_neighbor_update verification clean");
    else
      $display("bias_field_neighbor_update verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/bfnu_pkg.sv
hdl/bfnu_div.sv
hdl/bias_field_neighbor_update.sv
verif/tb.sv
